@@ rtl/core/camera_text_message_parser_assert.svh @@
// ----------------------------------------------------------------------------
// camera text message parser assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef CAMERA_TEXT_MESSAGE_PARSER_ASSERT_SVH
`define CAMERA_TEXT_MESSAGE_PARSER_ASSERT_SVH

// same-cycle implication
`define CTMP_ASSERT_SAME(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("ctmp assertion failed");

// next-cycle implication
`define CTMP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("ctmp assertion failed");

`endif

@@ rtl/core/ctmp_pkg.sv @@
// ----------------------------------------------------------------------------
// ctmp_pkg
// constants, codes and type tables of the camera text message parser
// ----------------------------------------------------------------------------
package ctmp_pkg;

  // token and value limits
  localparam int unsigned MAX_TOKEN_LEN = 32;
  localparam int unsigned MAX_VALUES    = 32;
  localparam int unsigned CHAR_W        = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned VAL_W         = $clog2(MAX_VALUES + 1);

  // characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_F     = 8'h46;

  // message kinds
  localparam logic [3:0] KIND_T1 = 4'd0;
  localparam logic [3:0] KIND_N1 = 4'd1;
  localparam logic [3:0] KIND_D1 = 4'd2;
  localparam logic [3:0] KIND_T2 = 4'd3;
  localparam logic [3:0] KIND_N2 = 4'd4;
  localparam logic [3:0] KIND_D2 = 4'd5;
  localparam logic [3:0] KIND_F2 = 4'd6;
  localparam logic [3:0] KIND_T3 = 4'd7;
  localparam logic [3:0] KIND_N3 = 4'd8;
  localparam logic [3:0] KIND_D3 = 4'd9;
  localparam logic [3:0] KIND_F3 = 4'd10;

  // result item kinds
  localparam logic [2:0] ITEM_ID    = 3'd0;
  localparam logic [2:0] ITEM_COORD = 3'd1;
  localparam logic [2:0] ITEM_DIM   = 3'd2;
  localparam logic [2:0] ITEM_EXTRA = 3'd3;
  localparam logic [2:0] ITEM_END   = 3'd4;
  localparam logic [2:0] ITEM_ABORT = 3'd5;

  // letter index: T, N, D, F
  localparam logic [1:0] LET_T = 2'd0;
  localparam logic [1:0] LET_N = 2'd1;
  localparam logic [1:0] LET_D = 2'd2;
  localparam logic [1:0] LET_F = 2'd3;

  // kind from letter and digit (digit 0..2); F1 does not exist
  function automatic logic [4:0] kind_lookup(logic [1:0] letter, logic [1:0] digit);
    logic [3:0] k;
    logic       ok;
    ok = 1'b1;
    k  = KIND_T1;
    case ({letter, digit})
      {LET_T, 2'd0}: k = KIND_T1;
      {LET_T, 2'd1}: k = KIND_T2;
      {LET_T, 2'd2}: k = KIND_T3;
      {LET_N, 2'd0}: k = KIND_N1;
      {LET_N, 2'd1}: k = KIND_N2;
      {LET_N, 2'd2}: k = KIND_N3;
      {LET_D, 2'd0}: k = KIND_D1;
      {LET_D, 2'd1}: k = KIND_D2;
      {LET_D, 2'd2}: k = KIND_D3;
      {LET_F, 2'd1}: k = KIND_F2;
      {LET_F, 2'd2}: k = KIND_F3;
      default:       ok = 1'b0;
    endcase
    return {ok, k};
  endfunction

  // fixed value count per kind (F kinds take it from the count token)
  function automatic logic [3:0] value_count_of(logic [3:0] kind);
    logic [3:0] n;
    case (kind)
      KIND_T1, KIND_N1:          n = 4'd1;
      KIND_D1, KIND_T2, KIND_N2: n = 4'd2;
      KIND_D2:                   n = 4'd8;
      KIND_T3, KIND_N3, KIND_D3: n = 4'd3;
      default:                   n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/core/camera_text_message_parser.sv @@
// ----------------------------------------------------------------------------
// camera_text_message_parser
// parses a line-based camera text protocol one character at a time and emits
// id characters, coordinates, dimensions, extra characters, end and abort markers
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-----------------------------
//  in       | input     | in_valid_i / in_stall_o | rx_byte_i
//  out      | output    | out_valid_o / out_stall_i | message_kind_o, item_kind_o,
//           |           |                        | item_index_o, item_value_o,
//           |           |                        | last_of_message_o
//
// one word per cycle sustained while out_stall_i does not hold a result; a
// word's result passes the input register, then the result register
// the parse step is a single pass from the input register to the result
// register, the decimal accumulate being a shift-add by ten
// a stalled result holds the result register; a word that makes no result
// still moves through, only a word that makes one waits for the register
// reset is asynchronous and puts the parser in newline search
// ----------------------------------------------------------------------------
module camera_text_message_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [3:0]         message_kind_o,
  output logic [2:0]         item_kind_o,
  output logic [4:0]         item_index_o,
  output logic signed [16:0] item_value_o,
  output logic               last_of_message_o
);
  import ctmp_pkg::*;

  typedef enum logic [3:0] {
    PH_SYNC      = 4'd0,
    PH_TYPE      = 4'd1,
    PH_ID        = 4'd2,
    PH_SIZE      = 4'd3,
    PH_COORD     = 4'd4,
    PH_DIM       = 4'd5,
    PH_QUAT      = 4'd6,
    PH_EXTRA     = 4'd7,
    PH_END_NL    = 4'd8,
    PH_END_PLAIN = 4'd9
  } phase_e;

  // input register
  logic       in_full_q, in_full_d;
  logic [7:0] rx_byte_q;

  // parser state
  phase_e            phase_q, phase_d;
  logic [7:0]        type_chars_q [2];
  logic [7:0]        type_chars_d [2];
  logic [3:0]        current_kind_q, current_kind_d;
  logic [VAL_W-1:0]  values_expected_q, values_expected_d;
  logic [VAL_W-1:0]  value_count_q, value_count_d;
  logic [CHAR_W-1:0] char_count_q, char_count_d;
  logic [15:0]       acc_q, acc_d;
  logic              neg_q, neg_d;
  logic              digits_ended_q, digits_ended_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic [3:0]        res_kind_q;
  logic [2:0]        res_item_q;
  logic [4:0]        res_index_q;
  logic [16:0]       res_value_q;
  logic              res_last_q;

  // step results
  logic        res_valid;
  logic [2:0]  res_item;
  logic [4:0]  res_index;
  logic [16:0] res_value;
  logic        res_last;
  logic        abort;
  logic        fire;
  logic        out_free;
  logic        delim;
  logic        is_digit;
  logic [15:0] tok_val;
  logic [15:0] acc_x10;
  logic [1:0]  letter;
  logic        letter_ok;
  logic [4:0]  kind_hit;
  logic [VAL_W-1:0] vc_next;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_full_q && (out_free || !res_valid);
  assign in_stall_o = in_full_q && !fire;

  // character classes and token value
  assign delim    = (rx_byte_q == CH_SP) || (rx_byte_q == CH_LF) ||
                    (rx_byte_q == CH_CR) || (rx_byte_q == CH_NUL);
  assign is_digit = (rx_byte_q >= CH_ZERO) && (rx_byte_q <= CH_NINE);
  assign tok_val  = neg_q ? 16'(16'd0 - acc_q) : acc_q;
  assign acc_x10  = 16'({acc_q, 3'b000} + {acc_q, 1'b0});
  assign vc_next  = value_count_q + VAL_W'(1);

  // type letter decode
  always_comb begin
    letter_ok = 1'b1;
    letter    = LET_T;
    case (type_chars_q[0])
      CH_T:    letter = LET_T;
      CH_N:    letter = LET_N;
      CH_D:    letter = LET_D;
      CH_F:    letter = LET_F;
      default: letter_ok = 1'b0;
    endcase
  end

  assign kind_hit = kind_lookup(letter, 2'(type_chars_q[1] - CH_ONE));

  // parse step
  always_comb begin
    phase_d           = phase_q;
    type_chars_d      = type_chars_q;
    current_kind_d    = current_kind_q;
    values_expected_d = values_expected_q;
    value_count_d     = value_count_q;
    char_count_d      = char_count_q;
    acc_d             = acc_q;
    neg_d             = neg_q;
    digits_ended_d    = digits_ended_q;
    res_valid         = 1'b0;
    res_item          = ITEM_END;
    res_index         = 5'd0;
    res_value         = 17'd0;
    res_last          = 1'b0;
    abort             = 1'b0;

    case (phase_q)
      PH_SYNC: begin
        if (rx_byte_q == CH_LF) begin
          phase_d      = PH_TYPE;
          char_count_d = '0;
        end
      end

      PH_TYPE: begin
        if (char_count_q < CHAR_W'(2)) begin
          type_chars_d[char_count_q[0]] = rx_byte_q;
          char_count_d = char_count_q + CHAR_W'(1);
        end else begin
          char_count_d   = '0;
          acc_d          = '0;
          neg_d          = 1'b0;
          digits_ended_d = 1'b0;
          if (letter_ok && (type_chars_q[1] >= CH_ONE) &&
              (type_chars_q[1] <= CH_THREE) && kind_hit[4]) begin
            current_kind_d    = kind_hit[3:0];
            values_expected_d = VAL_W'(value_count_of(kind_hit[3:0]));
            value_count_d     = '0;
            phase_d           = (letter == LET_T) ? PH_COORD : PH_ID;
          end else begin
            phase_d = PH_SYNC;
          end
        end
      end

      PH_ID, PH_EXTRA: begin
        if (delim) begin
          char_count_d   = '0;
          acc_d          = '0;
          neg_d          = 1'b0;
          digits_ended_d = 1'b0;
          if (phase_q == PH_ID) begin
            phase_d = (current_kind_q inside {KIND_F2, KIND_F3}) ? PH_SIZE : PH_COORD;
          end else begin
            phase_d   = (rx_byte_q == CH_LF) ? PH_TYPE : PH_SYNC;
            res_valid = 1'b1;
            res_item  = ITEM_END;
            res_last  = 1'b1;
          end
        end else if (char_count_q >= CHAR_W'(MAX_TOKEN_LEN - 1)) begin
          abort = 1'b1;
        end else begin
          char_count_d = char_count_q + CHAR_W'(1);
          res_valid    = 1'b1;
          res_item     = (phase_q == PH_ID) ? ITEM_ID : ITEM_EXTRA;
          res_index    = 5'(char_count_q);
          res_value    = {9'd0, rx_byte_q};
        end
      end

      PH_SIZE, PH_COORD, PH_DIM, PH_QUAT: begin
        if (!delim) begin
          // number character
          if (char_count_q >= CHAR_W'(MAX_TOKEN_LEN - 1)) begin
            abort = 1'b1;
          end else begin
            if ((char_count_q == '0) &&
                ((rx_byte_q == CH_MINUS) || (rx_byte_q == CH_PLUS))) begin
              neg_d = (rx_byte_q == CH_MINUS);
            end else if (is_digit && !digits_ended_q) begin
              acc_d = 16'(acc_x10 + {12'd0, rx_byte_q[3:0]});
            end else begin
              digits_ended_d = 1'b1;
            end
            char_count_d = char_count_q + CHAR_W'(1);
          end
        end else begin
          // token complete
          char_count_d   = '0;
          acc_d          = '0;
          neg_d          = 1'b0;
          digits_ended_d = 1'b0;
          case (phase_q)
            PH_SIZE: begin
              if ((tok_val == 16'd0) || (tok_val > 16'(MAX_VALUES))) begin
                abort = 1'b1;
              end else begin
                values_expected_d = VAL_W'(tok_val);
                value_count_d     = '0;
                phase_d           = PH_COORD;
              end
            end
            PH_QUAT: begin
              if (vc_next >= VAL_W'(4)) begin
                value_count_d = '0;
                phase_d       = PH_EXTRA;
              end else begin
                value_count_d = vc_next;
              end
            end
            default: begin
              res_valid = 1'b1;
              res_index = 5'(value_count_q);
              if (phase_q == PH_COORD) begin
                res_item  = ITEM_COORD;
                res_value = {tok_val[15], tok_val};
              end else begin
                res_item  = ITEM_DIM;
                res_value = {1'b0, tok_val};
              end
              value_count_d = vc_next;
              if (vc_next >= values_expected_q) begin
                value_count_d = '0;
                if (phase_q == PH_COORD) begin
                  if (current_kind_q inside {KIND_T1, KIND_T2, KIND_T3}) begin
                    phase_d = (rx_byte_q == CH_LF) ? PH_END_NL : PH_END_PLAIN;
                  end else if (current_kind_q inside {KIND_N1, KIND_N2, KIND_N3,
                                                      KIND_D3}) begin
                    phase_d = PH_DIM;
                  end else begin
                    phase_d = PH_EXTRA;
                  end
                end else if (current_kind_q == KIND_D3) begin
                  phase_d = PH_QUAT;
                end else begin
                  phase_d = (rx_byte_q == CH_LF) ? PH_END_NL : PH_END_PLAIN;
                end
              end
            end
          endcase
        end
      end

      PH_END_NL: begin
        type_chars_d[0] = rx_byte_q;
        char_count_d    = CHAR_W'(1);
        phase_d         = PH_TYPE;
        res_valid       = 1'b1;
        res_item        = ITEM_END;
        res_last        = 1'b1;
      end

      PH_END_PLAIN: begin
        char_count_d = '0;
        phase_d      = (rx_byte_q == CH_LF) ? PH_TYPE : PH_SYNC;
        res_valid    = 1'b1;
        res_item     = ITEM_END;
        res_last     = 1'b1;
      end

      default: begin
        phase_d = PH_SYNC;
      end
    endcase

    // abort closes the message and resyncs
    if (abort) begin
      phase_d        = PH_SYNC;
      char_count_d   = '0;
      acc_d          = '0;
      neg_d          = 1'b0;
      digits_ended_d = 1'b0;
      res_valid      = 1'b1;
      res_item       = ITEM_ABORT;
      res_index      = 5'd0;
      res_value      = 17'd0;
      res_last       = 1'b1;
    end
  end

  // input and result register handshakes
  always_comb begin
    if (in_valid_i && !in_stall_o) begin
      in_full_d = 1'b1;
    end else if (fire) begin
      in_full_d = 1'b0;
    end else begin
      in_full_d = in_full_q;
    end
    if (fire && res_valid) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q         <= 1'b0;
      out_valid_q       <= 1'b0;
      phase_q           <= PH_SYNC;
      type_chars_q[0]   <= 8'd0;
      type_chars_q[1]   <= 8'd0;
      current_kind_q    <= KIND_T1;
      values_expected_q <= '0;
      value_count_q     <= '0;
      char_count_q      <= '0;
      acc_q             <= '0;
      neg_q             <= 1'b0;
      digits_ended_q    <= 1'b0;
    end else begin
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        phase_q           <= phase_d;
        type_chars_q      <= type_chars_d;
        current_kind_q    <= current_kind_d;
        values_expected_q <= values_expected_d;
        value_count_q     <= value_count_d;
        char_count_q      <= char_count_d;
        acc_q             <= acc_d;
        neg_q             <= neg_d;
        digits_ended_q    <= digits_ended_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_byte_q <= rx_byte_i;
    end
    if (fire && res_valid) begin
      res_kind_q  <= current_kind_q;
      res_item_q  <= res_item;
      res_index_q <= res_index;
      res_value_q <= res_value;
      res_last_q  <= res_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign message_kind_o    = res_kind_q;
  assign item_kind_o       = res_item_q;
  assign item_index_o      = res_index_q;
  assign item_value_o      = signed'(res_value_q);
  assign last_of_message_o = res_last_q;

  // checks
`include "camera_text_message_parser_assert.svh"

  `CTMP_ASSERT_SAME(a_marker_clean, clk_i, rst_ni,
                    out_valid_o && last_of_message_o,
                    (item_index_o == 5'd0) && (item_value_o == 17'sd0))
  `CTMP_ASSERT_SAME(a_last_matches_item, clk_i, rst_ni, out_valid_o,
                    last_of_message_o == ((item_kind_o == ITEM_END) ||
                                          (item_kind_o == ITEM_ABORT)))
  `CTMP_ASSERT_NEXT(a_sync_holds, clk_i, rst_ni,
                    fire && (phase_q == PH_SYNC) && (rx_byte_q != CH_LF),
                    phase_q == PH_SYNC)
  `CTMP_ASSERT_SAME(a_kind_range, clk_i, rst_ni, out_valid_o,
                    message_kind_o <= KIND_F3)

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// drives the text message parser one character per word: a short table of
// directed words, then random message lines with noise and broken lines,
// and checks every result word against its typed row or a local parse of the same bytes
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctmp_pkg::*;

  localparam int unsigned RANDOM_WORDS    = 1150;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned MAX_PRINTED     = 20;
  localparam logic [7:0]  CH_TWO          = 8'h32;

  typedef enum logic [3:0] {
    PH_SYNC, PH_TYPE, PH_ID, PH_SIZE, PH_COORD, PH_DIM, PH_QUAT, PH_EXTRA,
    PH_END_NL, PH_END_PLAIN
  } parse_phase_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic [2:0]         item;
    logic [4:0]         idx;
    logic signed [16:0] value;
    logic               last;
  } parse_result_t;

  typedef struct packed {
    logic          typed;
    logic          has_res;
    parse_result_t res;
  } table_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [3:0]         message_kind_o;
  logic [2:0]         item_kind_o;
  logic [4:0]         item_index_o;
  logic signed [16:0] item_value_o;
  logic               last_of_message_o;

  // stimulus and expectations
  logic [7:0]    rx_words [$];
  table_row_t    table_rows [$];
  parse_result_t pending_items [$];
  logic [7:0]    last_delim;

  // local copy of the parser state
  parse_phase_e m_phase;
  logic [7:0]   m_type [2];
  logic [3:0]   m_kind;
  logic [5:0]   m_expected;
  logic [5:0]   m_count;
  logic [5:0]   m_chars;
  logic [15:0]  m_acc;
  logic         m_neg;
  logic         m_ended;

  // run bookkeeping
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned n_values, n_chars, n_ends, n_aborts;
  int unsigned mismatches;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          hold_off_req;
  bit          hold_off_done;

  camera_text_message_parser dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .message_kind_o    (message_kind_o),
    .item_kind_o       (item_kind_o),
    .item_index_o      (item_index_o),
    .item_value_o      (item_value_o),
    .last_of_message_o (last_of_message_o)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- parse

  function automatic bit is_separator(logic [7:0] c);
    return c == CH_SP || c == CH_LF || c == CH_CR || c == CH_NUL;
  endfunction

  // coordinates per kind; dimensions use the same count
  function automatic logic [5:0] values_for(logic [3:0] kind);
    case (kind)
      KIND_T1, KIND_N1:          return 6'd1;
      KIND_D1, KIND_T2, KIND_N2: return 6'd2;
      KIND_D2:                   return 6'd8;
      KIND_T3, KIND_N3, KIND_D3: return 6'd3;
      default:                   return 6'd0;
    endcase
  endfunction

  function automatic void clear_token_state();
    m_chars = '0;
    m_acc   = '0;
    m_neg   = 1'b0;
    m_ended = 1'b0;
  endfunction

  // one word through the parser; returns 1 when it makes a result
  function automatic bit parse_word(input logic [7:0] c, output parse_result_t r);
    logic [15:0] v;
    logic [3:0]  k;
    bit          ok;
    bit          is_coord;
    r = '{m_kind, ITEM_END, 5'd0, 17'sd0, 1'b1};
    parse_word = 1'b0;
    case (m_phase)
      PH_SYNC: begin
        if (c == CH_LF) begin
          m_phase = PH_TYPE;
          m_chars = '0;
        end
      end
      PH_TYPE: begin
        if (m_chars < 2) begin
          m_type[m_chars[0]] = c;
          m_chars = m_chars + 6'd1;
        end else begin
          clear_token_state();
          ok = 1'b1;
          k  = KIND_T1;
          case ({m_type[0], m_type[1]})
            {CH_T, CH_ONE}:   k = KIND_T1;
            {CH_T, CH_TWO}:   k = KIND_T2;
            {CH_T, CH_THREE}: k = KIND_T3;
            {CH_N, CH_ONE}:   k = KIND_N1;
            {CH_N, CH_TWO}:   k = KIND_N2;
            {CH_N, CH_THREE}: k = KIND_N3;
            {CH_D, CH_ONE}:   k = KIND_D1;
            {CH_D, CH_TWO}:   k = KIND_D2;
            {CH_D, CH_THREE}: k = KIND_D3;
            {CH_F, CH_TWO}:   k = KIND_F2;
            {CH_F, CH_THREE}: k = KIND_F3;
            default:          ok = 1'b0;
          endcase
          if (!ok) begin
            m_phase = PH_SYNC;
          end else begin
            m_kind     = k;
            m_expected = values_for(k);
            m_count    = '0;
            m_phase    = (m_type[0] == CH_T) ? PH_COORD : PH_ID;
          end
        end
      end
      PH_ID, PH_EXTRA: begin
        if (is_separator(c)) begin
          clear_token_state();
          if (m_phase == PH_ID) begin
            m_phase = (m_kind == KIND_F2 || m_kind == KIND_F3) ? PH_SIZE : PH_COORD;
          end else begin
            // extra ends the message at its own delimiter
            m_phase = (c == CH_LF) ? PH_TYPE : PH_SYNC;
            parse_word = 1'b1;
          end
        end else if (m_chars >= MAX_TOKEN_LEN - 1) begin
          m_phase = PH_SYNC;
          clear_token_state();
          r.item = ITEM_ABORT;
          parse_word = 1'b1;
        end else begin
          r.item  = (m_phase == PH_ID) ? ITEM_ID : ITEM_EXTRA;
          r.idx   = m_chars[4:0];
          r.value = {9'd0, c};
          r.last  = 1'b0;
          m_chars = m_chars + 6'd1;
          parse_word = 1'b1;
        end
      end
      PH_SIZE, PH_COORD, PH_DIM, PH_QUAT: begin
        if (!is_separator(c)) begin
          if (m_chars >= MAX_TOKEN_LEN - 1) begin
            m_phase = PH_SYNC;
            clear_token_state();
            r.item = ITEM_ABORT;
            parse_word = 1'b1;
          end else begin
            // sign only in first position, digits until the first other character
            if (m_chars == 0 && (c == CH_MINUS || c == CH_PLUS))
              m_neg = (c == CH_MINUS);
            else if (c >= CH_ZERO && c <= CH_NINE && !m_ended)
              m_acc = m_acc * 16'd10 + c - CH_ZERO;
            else
              m_ended = 1'b1;
            m_chars = m_chars + 6'd1;
          end
        end else begin
          v = m_neg ? 16'd0 - m_acc : m_acc;
          clear_token_state();
          case (m_phase)
            PH_SIZE: begin
              if (v == 0 || v > MAX_VALUES) begin
                m_phase = PH_SYNC;
                r.item = ITEM_ABORT;
                parse_word = 1'b1;
              end else begin
                m_expected = v[5:0];
                m_count    = '0;
                m_phase    = PH_COORD;
              end
            end
            PH_QUAT: begin
              // quaternion tokens are read and dropped
              m_count = m_count + 6'd1;
              if (m_count >= 4) begin
                m_count = '0;
                m_phase = PH_EXTRA;
              end
            end
            default: begin
              is_coord = (m_phase == PH_COORD);
              r.item  = is_coord ? ITEM_COORD : ITEM_DIM;
              r.idx   = m_count[4:0];
              r.value = is_coord ? {v[15], v} : {1'b0, v};
              r.last  = 1'b0;
              m_count = m_count + 6'd1;
              if (m_count >= m_expected) begin
                m_count = '0;
                if (is_coord) begin
                  case (m_kind)
                    KIND_T1, KIND_T2, KIND_T3:
                      m_phase = (c == CH_LF) ? PH_END_NL : PH_END_PLAIN;
                    KIND_N1, KIND_N2, KIND_N3, KIND_D3:
                      m_phase = PH_DIM;
                    default:
                      m_phase = PH_EXTRA;
                  endcase
                end else if (m_kind == KIND_D3) begin
                  m_phase = PH_QUAT;
                end else begin
                  m_phase = (c == CH_LF) ? PH_END_NL : PH_END_PLAIN;
                end
              end
              parse_word = 1'b1;
            end
          endcase
        end
      end
      PH_END_NL: begin
        // end marker rides on the first type character of the next line
        m_type[0] = c;
        m_chars   = 6'd1;
        m_phase   = PH_TYPE;
        parse_word = 1'b1;
      end
      PH_END_PLAIN: begin
        m_chars = '0;
        m_phase = (c == CH_LF) ? PH_TYPE : PH_SYNC;
        parse_word = 1'b1;
      end
      default: m_phase = PH_SYNC;
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  // directed rows: checked by the local parse
  task automatic dir_word(input logic [7:0] c);
    rx_words.push_back(c);
    table_rows.push_back('{1'b0, 1'b0, '0});
  endtask

  // directed rows known to make no result
  task automatic dir_quiet(input logic [7:0] c);
    rx_words.push_back(c);
    table_rows.push_back('{1'b1, 1'b0, '0});
  endtask

  task automatic dir_typed(input logic [7:0] c, input logic [3:0] kind, input logic [2:0] item,
                           input logic [4:0] idx, input logic signed [16:0] value,
                           input logic last);
    rx_words.push_back(c);
    table_rows.push_back('{1'b1, 1'b1, '{kind, item, idx, value, last}});
  endtask

  function automatic logic [7:0] any_delim();
    case ($urandom_range(0, 11))
      0:       return CH_CR;
      1:       return CH_NUL;
      2:       return CH_LF;
      default: return CH_SP;
    endcase
  endfunction

  function automatic void end_token();
    last_delim = any_delim();
    rx_words.push_back(last_delim);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_words.push_back(s[i]);
  endfunction

  // id or extra: mostly short, sometimes the longest allowed or one more
  function automatic void add_text_token();
    int unsigned len;
    logic [7:0]  c;
    case ($urandom_range(0, 29))
      0:       len = MAX_TOKEN_LEN - 1;
      1:       len = MAX_TOKEN_LEN;
      default: len = $urandom_range(0, 6);
    endcase
    repeat (len) begin
      do c = 8'($urandom_range(0, 255)); while (is_separator(c));
      rx_words.push_back(c);
    end
    end_token();
  endfunction

  function automatic void add_number_token();
    string       sign;
    int unsigned len;
    logic [7:0]  junk;
    case ($urandom_range(0, 5))
      0, 1:    sign = "-";
      2:       sign = "+";
      default: sign = "";
    endcase
    case ($urandom_range(0, 39))
      0: ;  // empty token
      1, 2: begin
        // long digit runs near the token limit
        len = $urandom_range(MAX_TOKEN_LEN - 4, MAX_TOKEN_LEN);
        repeat (len) rx_words.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      3, 4: begin
        junk = 8'($urandom_range(8'h3A, 8'h7E));
        push_text($sformatf("%s%0d%c%0d", sign, $urandom_range(0, 999), junk,
                            $urandom_range(0, 99)));
      end
      5, 6, 7: push_text({sign, $sformatf("%0d", $urandom_range(30000, 99999))});
      default: push_text({sign, $sformatf("%0d", $urandom_range(0, 9999))});
    endcase
    end_token();
  endfunction

  function automatic void add_message();
    logic [3:0]  k;
    logic [7:0]  lt, dg, sep;
    int          n;
    k = 4'($urandom_range(0, 10));
    if (last_delim != CH_LF) rx_words.push_back(CH_LF);
    case (k)
      KIND_T1: begin lt = CH_T; dg = CH_ONE;   end
      KIND_T2: begin lt = CH_T; dg = CH_TWO;   end
      KIND_T3: begin lt = CH_T; dg = CH_THREE; end
      KIND_N1: begin lt = CH_N; dg = CH_ONE;   end
      KIND_N2: begin lt = CH_N; dg = CH_TWO;   end
      KIND_N3: begin lt = CH_N; dg = CH_THREE; end
      KIND_D1: begin lt = CH_D; dg = CH_ONE;   end
      KIND_D2: begin lt = CH_D; dg = CH_TWO;   end
      KIND_D3: begin lt = CH_D; dg = CH_THREE; end
      KIND_F2: begin lt = CH_F; dg = CH_TWO;   end
      default: begin lt = CH_F; dg = CH_THREE; end
    endcase
    rx_words.push_back(lt);
    rx_words.push_back(dg);
    // the separator after the type may be any byte
    sep = 8'($urandom_range(0, 255));
    rx_words.push_back(($urandom_range(0, 9) == 0) ? sep : CH_SP);
    n = int'(values_for(k));
    if (lt != CH_T) add_text_token();
    if (lt == CH_F) begin
      case ($urandom_range(0, 15))
        0:       n = MAX_VALUES;
        1:       n = 0;
        2:       n = -$urandom_range(1, 9);
        3:       n = MAX_VALUES + $urandom_range(1, 60);
        default: n = $urandom_range(1, 4);
      endcase
      push_text($sformatf("%0d", n));
      end_token();
      if (n < 1 || n > MAX_VALUES) n = $urandom_range(1, 3);
    end
    repeat (n) add_number_token();
    if (lt == CH_N || k == KIND_D3) repeat (n) add_number_token();
    if (k == KIND_D3) repeat (4) add_number_token();
    if (lt == CH_D || lt == CH_F) add_text_token();
  endfunction

  function automatic void build_random_lines();
    int unsigned target;
    logic [7:0]  c;
    target = rx_words.size() + RANDOM_WORDS;
    last_delim = CH_NUL;
    while (rx_words.size() < target) begin
      case ($urandom_range(0, 15))
        0: begin
          // line noise
          repeat ($urandom_range(1, 12)) begin
            c = 8'($urandom_range(0, 255));
            rx_words.push_back(c);
          end
          last_delim = CH_NUL;
        end
        1: begin
          // bad or unknown type, then junk
          if (last_delim != CH_LF) rx_words.push_back(CH_LF);
          c = 8'($urandom_range(0, 255));
          rx_words.push_back(($urandom_range(0, 1) == 0) ? CH_F : c);
          c = 8'($urandom_range(0, 255));
          rx_words.push_back(($urandom_range(0, 1) == 0) ? CH_ONE : c);
          rx_words.push_back(CH_SP);
          add_text_token();
        end
        2: begin
          // line cut short
          add_message();
          repeat ($urandom_range(1, 3)) void'(rx_words.pop_back());
          last_delim = CH_NUL;
        end
        default: add_message();
      endcase
    end
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input parse_result_t seen,
                                 input parse_result_t want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] mismatch: %s | got %0d/%0d/%0d/%0d/%0b want %0d/%0d/%0d/%0d/%0b",
               $realtime, what, seen.kind, seen.item, seen.idx, seen.value, seen.last,
               want.kind, want.item, want.idx, want.value, want.last);
  endtask

  // predict at the input handshake, compare at the output handshake
  always @(posedge clk_i) begin : result_check
    parse_result_t pred, seen, want;
    bit            got, acc_in, acc_out;
    string         bad;
    int unsigned   stuck_cycles;
    acc_in  = rst_ni && in_valid_i && !in_stall_o;
    acc_out = rst_ni && out_valid_o && !out_stall_i;
    if (acc_in) begin
      got = parse_word(rx_byte_i, pred);
      if (words_sent < table_rows.size() && table_rows[words_sent].typed) begin
        if (table_rows[words_sent].has_res) pending_items.push_back(table_rows[words_sent].res);
      end else if (got) begin
        pending_items.push_back(pred);
      end
      words_sent++;
    end
    if (acc_out) begin
      seen = '{message_kind_o, item_kind_o, item_index_o, item_value_o, last_of_message_o};
      results_seen++;
      case (seen.item)
        ITEM_COORD, ITEM_DIM: n_values++;
        ITEM_ID, ITEM_EXTRA:  n_chars++;
        ITEM_END:             n_ends++;
        ITEM_ABORT:           n_aborts++;
        default: ;
      endcase
      if (pending_items.size() == 0) begin
        report_mismatch("result with nothing expected", seen, '0);
      end else begin
        want = pending_items.pop_front();
        bad = "";
        if (seen.kind !== want.kind)   bad = {bad, " kind"};
        if (seen.item !== want.item)   bad = {bad, " item"};
        if (seen.idx !== want.idx)     bad = {bad, " index"};
        if (seen.value !== want.value) bad = {bad, " value"};
        if (seen.last !== want.last)   bad = {bad, " last"};
        if (bad != "") report_mismatch({"wrong", bad}, seen, want);
      end
    end
    // watchdog on handshakes
    if (!rst_ni || acc_in || acc_out) stuck_cycles = 0;
    else stuck_cycles++;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               stuck_cycles, pending_items.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- handshakes

  // sender: idle mix follows progress through the word list
  initial begin : word_driver
    int unsigned pos;
    int unsigned total;
    pos = 0;
    while (!rst_ni) @(posedge clk_i);
    total = rx_words.size();
    forever begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) pos++;
      if (pos < total / 3) begin
        tx_idle_pct = 12;
        rx_idle_pct = 86;
      end else if (pos < 2 * total / 3) begin
        tx_idle_pct = 86;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
      end
      if (in_valid_i && in_stall_o) begin
        // stalled word holds
      end else if (pos < total && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        rx_byte_i  <= rx_words[pos];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- run

  initial begin : run_control
    m_phase    = PH_SYNC;
    m_type[0]  = '0;
    m_type[1]  = '0;
    m_kind     = '0;
    m_expected = '0;
    m_count    = '0;
    clear_token_state();
    tx_idle_pct = 12;
    rx_idle_pct = 86;

    // directed: ignored bytes before sync, most negative coordinate ending on
    // newline, end marker on the next type character, unknown type, zero count
    dir_quiet("A");
    dir_quiet(CH_NUL);
    dir_quiet(8'hFF);
    dir_quiet(CH_LF);
    dir_word(CH_T);
    dir_word(CH_ONE);
    dir_word(CH_SP);
    dir_word(CH_MINUS);
    dir_word("3");
    dir_word("2");
    dir_word("7");
    dir_word("6");
    dir_word("8");
    dir_typed(CH_LF, KIND_T1, ITEM_COORD, 5'd0, -17'sd32768, 1'b0);
    dir_typed("X", KIND_T1, ITEM_END, 5'd0, 17'sd0, 1'b1);
    dir_word(CH_ONE);
    dir_quiet(CH_SP);
    dir_word(CH_LF);
    dir_word(CH_F);
    dir_word(CH_TWO);
    dir_word(CH_SP);
    dir_typed("9", KIND_F2, ITEM_ID, 5'd0, 17'sh00039, 1'b0);
    dir_word(CH_SP);
    dir_word(CH_ZERO);
    dir_typed(CH_SP, KIND_F2, ITEM_ABORT, 5'd0, 17'sd0, 1'b1);
    build_random_lines();

    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_sent < rx_words.size() || pending_items.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d words (%0d directed) through sync, all eleven kinds, noise and cut lines",
             words_sent, table_rows.size());
    $display("checked %0d results: %0d values, %0d characters, %0d ends, %0d aborts; %0d bad",
             results_seen, n_values, n_chars, n_ends, n_aborts, mismatches);
    if (mismatches == 0 && pending_items.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
